### sv/smd_pkg.sv
// Package for the scaled multiply-divide block: mode codes, port width and
// the sideband record that travels down the divide pipeline. No dependencies.
`timescale 1ns / 1ps

package smd_pkg;

    // Width of every operand and result port
    localparam int PORT_W = 32;

    // Mode codes on the action port
    localparam logic ACT_SIGNED   = 1'b0;
    localparam logic ACT_UNSIGNED = 1'b1;

    // Per-transaction flags carried alongside the data
    typedef struct packed {
        logic neg;   // quotient must be negated at the end
        logic zdiv;  // divisor was zero, result forced to 0
    } smd_side_t;

endpackage

### sv/smd_div_stage.sv
// One registered step of the restoring divider: one quotient bit per stage.
// Depends on smd_pkg for the sideband record.
`timescale 1ns / 1ps

module smd_div_stage #(
    parameter int W = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  smd_pkg::smd_side_t in_side,
    input  logic [W-1:0]      in_rem,
    input  logic [2*W-1:0]    in_dq,
    input  logic [W-1:0]      in_dvs,
    output logic              out_valid,
    output smd_pkg::smd_side_t out_side,
    output logic [W-1:0]      out_rem,
    output logic [2*W-1:0]    out_dq,
    output logic [W-1:0]      out_dvs
);
    import smd_pkg::*;

    logic [W:0]     trial;
    logic [W+1:0]   diff;
    logic           q_bit;
    logic [W-1:0]   rem_next;
    logic [2*W-1:0] dq_next;

    logic           valid_reg;
    smd_side_t      side_reg;
    logic [W-1:0]   rem_reg;
    logic [2*W-1:0] dq_reg;
    logic [W-1:0]   dvs_reg;

    // Shift in the next dividend bit and try subtracting the divisor
    always_comb
    begin
        trial    = {in_rem, in_dq[2*W-1]};
        diff     = {1'b0, trial} - {2'b00, in_dvs};
        q_bit    = ~diff[W+1];
        rem_next = q_bit ? diff[W-1:0] : trial[W-1:0];
        dq_next  = {in_dq[2*W-2:0], q_bit};
    end

    // Valid bit is control state; payload needs no reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg <= in_side;
        rem_reg  <= rem_next;
        dq_reg   <= dq_next;
        dvs_reg  <= in_dvs;
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_rem   = rem_reg;
    assign out_dq    = dq_reg;
    assign out_dvs   = dvs_reg;

endmodule

### sv/scaled_multiply_divide.sv
// Top level of the scaled multiply-divide block: operand conditioning,
// multiplier, divider chain and result register. Uses smd_pkg, smd_div_stage.
`timescale 1ns / 1ps

// Computes the low OPERAND_WIDTH bits of (multiplicand * multiplier) / divisor,
// signed (action = 0, truncating toward zero) or unsigned (action = 1).
// Operand bits above OPERAND_WIDTH are ignored; the quotient is zero-extended
// to 32 bits. A zero divisor returns quotient 0 with zero_divisor set.
// The block is fully pipelined: busy is always low and a transaction may be
// started in every cycle. Between start and done lie an operand stage, a
// multiplier stage, the divider chain (one stage per quotient bit over the
// double-width product) and the output register, in that order.
// Results cannot be held off, so done must be taken when seen.
module scaled_multiply_divide #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       action,
    input  logic [smd_pkg::PORT_W-1:0] multiplicand,
    input  logic [smd_pkg::PORT_W-1:0] multiplier,
    input  logic [smd_pkg::PORT_W-1:0] divisor,
    output logic                       done,
    output logic [smd_pkg::PORT_W-1:0] quotient,
    output logic                       zero_divisor
);
    import smd_pkg::*;

    localparam int W       = OPERAND_WIDTH;
    localparam int STEPS   = 2 * W;
    localparam int LATENCY = STEPS + 3;

    // Operand stage
    logic         signed_mode;
    logic [W-1:0] op_a, op_b, op_d;
    logic         neg_a, neg_b, neg_d;
    logic         a_valid_reg;
    smd_side_t    a_side_reg;
    logic [W-1:0] a_mag_a_reg, a_mag_b_reg, a_mag_d_reg;

    // Multiplier stage
    logic           b_valid_reg;
    smd_side_t      b_side_reg;
    logic [2*W-1:0] b_prod_reg;
    logic [W-1:0]   b_dvs_reg;

    // Divider chain links
    logic           chain_valid [0:STEPS];
    smd_side_t      chain_side  [0:STEPS];
    logic [W-1:0]   chain_rem   [0:STEPS];
    logic [2*W-1:0] chain_dq    [0:STEPS];
    logic [W-1:0]   chain_dvs   [0:STEPS];

    // Output stage
    logic              [W-1:0] q_low;
    logic              [W-1:0] q_fix;
    logic [PORT_W-1:0] quotient_next;
    logic              done_reg;
    logic [PORT_W-1:0] quotient_reg;
    logic              zero_reg;

    // Fully pipelined: never refuses a transaction
    assign busy = 1'b0;

    // Split operands into sign and magnitude
    always_comb
    begin
        signed_mode = (action == ACT_SIGNED);
        op_a  = multiplicand[W-1:0];
        op_b  = multiplier[W-1:0];
        op_d  = divisor[W-1:0];
        neg_a = signed_mode & op_a[W-1];
        neg_b = signed_mode & op_b[W-1];
        neg_d = signed_mode & op_d[W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start & ~busy;
            b_valid_reg <= a_valid_reg;
            done_reg    <= chain_valid[STEPS];
        end
    end

    // Operand and multiplier registers
    always_ff @(posedge clk)
    begin
        a_mag_a_reg     <= neg_a ? W'(~op_a + 1'b1) : op_a;
        a_mag_b_reg     <= neg_b ? W'(~op_b + 1'b1) : op_b;
        a_mag_d_reg     <= neg_d ? W'(~op_d + 1'b1) : op_d;
        a_side_reg.neg  <= neg_a ^ neg_b ^ neg_d;
        a_side_reg.zdiv <= (op_d == '0);

        b_prod_reg <= (2*W)'(a_mag_a_reg) * (2*W)'(a_mag_b_reg);
        b_dvs_reg  <= a_mag_d_reg;
        b_side_reg <= a_side_reg;
    end

    // Head of the divider chain: remainder starts at zero
    assign chain_valid[0] = b_valid_reg;
    assign chain_side[0]  = b_side_reg;
    assign chain_rem[0]   = '0;
    assign chain_dq[0]    = b_prod_reg;
    assign chain_dvs[0]   = b_dvs_reg;

    // One stage per quotient bit of the double-width dividend
    for (genvar i = 0; i < STEPS; i++)
    begin : g_div
        smd_div_stage #(
            .W (W)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_side   (chain_side[i]),
            .in_rem    (chain_rem[i]),
            .in_dq     (chain_dq[i]),
            .in_dvs    (chain_dvs[i]),
            .out_valid (chain_valid[i+1]),
            .out_side  (chain_side[i+1]),
            .out_rem   (chain_rem[i+1]),
            .out_dq    (chain_dq[i+1]),
            .out_dvs   (chain_dvs[i+1])
        );
    end

    // Sign fix-up, zero-divisor override
    always_comb
    begin
        q_low = chain_dq[STEPS][W-1:0];
        q_fix = chain_side[STEPS].neg ? W'(~q_low + 1'b1) : q_low;
        quotient_next = chain_side[STEPS].zdiv ? '0 : PORT_W'(q_fix);
    end

    always_ff @(posedge clk)
    begin
        quotient_reg <= quotient_next;
        zero_reg     <= chain_side[STEPS].zdiv;
    end

    assign done         = done_reg;
    assign quotient     = quotient_reg;
    assign zero_divisor = zero_reg;

`ifndef SYNTH
    // Every result traces back to a matching start
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without matching start");

    // Zero-divisor flag follows the divisor of the same transaction
    a_zero_flag_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (zero_divisor == $past(divisor[W-1:0] == '0, LATENCY)))
        else $error("zero_divisor does not match divisor");

    // A flagged result carries a zero quotient
    a_zero_quot: assert property (@(posedge clk) disable iff (!rst_n)
        (done && zero_divisor) |-> (quotient == '0))
        else $error("nonzero quotient on zero divisor");
`endif

endmodule

### tb/tb.sv
// Self-checking testbench for scaled_multiply_divide: a directed table, then random
// operand traffic in bursts. Typed table rows are checked against their own answer,
// others against a behavioural predictor. Uses smd_pkg, scaled_multiply_divide RTL.
`timescale 1ns / 1ps

module tb;

    import smd_pkg::*;

    localparam int OW        = 32;
    localparam int LATENCY   = 2 * OW + 3;
    localparam int N_RANDOM  = 1400;
    localparam int IDLE_MAX  = 4000;
    localparam int N_DIRECT  = 23;

    // One result transaction as seen on the output ports
    typedef struct packed {
        logic [PORT_W-1:0] quot;
        logic              zdiv;
    } muldiv_res_t;

    // One row of the directed table; typed rows carry their own answer
    typedef struct packed {
        logic              act;
        logic [PORT_W-1:0] a;
        logic [PORT_W-1:0] b;
        logic [PORT_W-1:0] d;
        logic              typed;
        logic [PORT_W-1:0] quot;
        logic              zdiv;
    } dir_row_t;

    localparam dir_row_t DIR_ROWS [0:N_DIRECT-1] = '{
        // zero divisor, both modes
        '{ACT_SIGNED,   32'h0000_0005, 32'h0000_0007, 32'h0000_0000, 1'b1, 32'h0, 1'b1},
        '{ACT_UNSIGNED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0, 1'b1},
        '{ACT_SIGNED,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0, 1'b1},
        '{ACT_SIGNED,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0, 1'b1},
        // unsigned extremes
        '{ACT_UNSIGNED, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 1'b1, 32'h0, 1'b0},
        '{ACT_UNSIGNED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          32'hFFFF_FFFF, 1'b0},
        '{ACT_UNSIGNED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1,
          32'h0000_0001, 1'b0},
        '{ACT_UNSIGNED, 32'h8000_0000, 32'h0000_0002, 32'h0000_0001, 1'b1, 32'h0, 1'b0},
        '{ACT_UNSIGNED, 32'h0000_0007, 32'h0000_0003, 32'h0000_0002, 1'b1,
          32'h0000_000A, 1'b0},
        '{ACT_UNSIGNED, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 1'b1,
          32'h0000_0001, 1'b0},
        '{ACT_UNSIGNED, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0},
        // signed: most negative over minus one wraps back to itself
        '{ACT_SIGNED,   32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1,
          32'h8000_0000, 1'b0},
        '{ACT_SIGNED,   32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 1'b1, 32'h0, 1'b0},
        '{ACT_SIGNED,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1,
          32'h0000_0001, 1'b0},
        '{ACT_SIGNED,   32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 1'b1,
          32'hFFFF_FFFF, 1'b0},
        '{ACT_SIGNED,   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
          32'h7FFF_FFFF, 1'b0},
        '{ACT_SIGNED,   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1,
          32'h8000_0000, 1'b0},
        // truncation toward zero with mixed signs
        '{ACT_SIGNED,   32'h0000_0007, 32'hFFFF_FFFD, 32'h0000_0002, 1'b1,
          32'hFFFF_FFF6, 1'b0},
        '{ACT_SIGNED,   32'hFFFF_FFF9, 32'h0000_0003, 32'hFFFF_FFFE, 1'b1,
          32'h0000_000A, 1'b0},
        '{ACT_SIGNED,   32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0, 1'b0},
        // left to the predictor
        '{ACT_UNSIGNED, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_0007, 1'b0, 32'h0, 1'b0},
        '{ACT_SIGNED,   32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0003, 1'b0, 32'h0, 1'b0},
        '{ACT_SIGNED,   32'hDEAD_BEEF, 32'hCAFE_BABE, 32'hFFFF_0001, 1'b0, 32'h0, 1'b0}
    };

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              action;
    logic [PORT_W-1:0] multiplicand;
    logic [PORT_W-1:0] multiplier;
    logic [PORT_W-1:0] divisor;
    logic              done;
    logic [PORT_W-1:0] quotient;
    logic              zero_divisor;

    // Typed answer that travels with the transaction being driven
    logic              typed_valid;
    muldiv_res_t       typed_res;

    muldiv_res_t       pending_q [$];
    int                err_cnt;
    int                idle_cycles;

    scaled_multiply_divide #(
        .OPERAND_WIDTH(OW)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .multiplicand (multiplicand),
        .multiplier   (multiplier),
        .divisor      (divisor),
        .done         (done),
        .quotient     (quotient),
        .zero_divisor (zero_divisor)
    );

    always #2 clk = ~clk;

    // Full-width product over divisor, sign-magnitude in signed mode
    function automatic muldiv_res_t predict_muldiv(input logic act, input logic [PORT_W-1:0] a,
                                                   input logic [PORT_W-1:0] b,
                                                   input logic [PORT_W-1:0] d);
        logic [63:0] mask;
        logic [63:0] av;
        logic [63:0] bv;
        logic [63:0] dv;
        logic [63:0] prod_q;
        logic        na;
        logic        nb;
        logic        nd;
        muldiv_res_t res;
        mask = (64'd1 << OW) - 64'd1;
        av   = {32'd0, a} & mask;
        bv   = {32'd0, b} & mask;
        dv   = {32'd0, d} & mask;
        if (dv == 64'd0)
        begin
            res.quot = '0;
            res.zdiv = 1'b1;
        end
        else
        begin
            if (act == ACT_UNSIGNED)
                prod_q = (av * bv) / dv;
            else
            begin
                na = av[OW-1];
                nb = bv[OW-1];
                nd = dv[OW-1];
                if (na) av = (~av + 64'd1) & mask;
                if (nb) bv = (~bv + 64'd1) & mask;
                if (nd) dv = (~dv + 64'd1) & mask;
                prod_q = (av * bv) / dv;
                if (na ^ nb ^ nd)
                    prod_q = ~prod_q + 64'd1;
            end
            prod_q   = prod_q & mask;
            res.quot = prod_q[PORT_W-1:0];
            res.zdiv = 1'b0;
        end
        return res;
    endfunction

    // Operand mix: full range, small, small negative, corner values, varied magnitude
    function automatic logic [PORT_W-1:0] rand_operand();
        logic [PORT_W-1:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom();
            2: v = $urandom_range(0, 255);
            3: v = 32'd0 - 32'($urandom_range(1, 255));
            4:
            begin
                case ($urandom_range(0, 5))
                    0: v = 32'h0000_0000;
                    1: v = 32'h0000_0001;
                    2: v = 32'h7FFF_FFFF;
                    3: v = 32'h8000_0000;
                    4: v = 32'hFFFF_FFFF;
                    default: v = 32'h8000_0001;
                endcase
            end
            default: v = $urandom() >> $urandom_range(0, 31);
        endcase
        return v;
    endfunction

    task automatic report_error(input string msg);
        if (err_cnt < 10)
            $display("tb: %s", msg);
        err_cnt++;
    endtask

    // Drive one transaction and hold it until it is taken
    task automatic send_txn(input logic act, input logic [PORT_W-1:0] a,
                            input logic [PORT_W-1:0] b, input logic [PORT_W-1:0] d,
                            input logic typed, input muldiv_res_t res);
        start        <= 1'b1;
        action       <= act;
        multiplicand <= a;
        multiplier   <= b;
        divisor      <= d;
        typed_valid  <= typed;
        typed_res    <= res;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Record expectations on acceptance, check results on done
    always @(posedge clk)
    begin
        muldiv_res_t want;
        if (rst_n && done)
        begin
            if (pending_q.size() == 0)
                report_error($sformatf("result with nothing pending: q=%h zd=%b",
                                       quotient, zero_divisor));
            else
            begin
                want = pending_q.pop_front();
                if (quotient !== want.quot || zero_divisor !== want.zdiv)
                    report_error($sformatf("mismatch: exp q=%h zd=%b, got q=%h zd=%b",
                                           want.quot, want.zdiv, quotient, zero_divisor));
            end
        end
        if (rst_n && start && !busy)
        begin
            if (typed_valid)
                pending_q.push_back(typed_res);
            else
                pending_q.push_back(predict_muldiv(action, multiplicand, multiplier, divisor));
        end
    end

    // Watchdog on cycles in which no transaction moves either way
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        int          i;
        int          n;
        int          k;
        int          burst;
        int          gap;
        logic        act;
        logic [PORT_W-1:0] a;
        logic [PORT_W-1:0] b;
        logic [PORT_W-1:0] d;
        muldiv_res_t none;
        rst_n        = 1'b0;
        start        = 1'b0;
        action       = ACT_SIGNED;
        multiplicand = '0;
        multiplier   = '0;
        divisor      = '0;
        typed_valid  = 1'b0;
        typed_res    = '0;
        none         = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, back to back
        for (i = 0; i < N_DIRECT; i++)
            send_txn(DIR_ROWS[i].act, DIR_ROWS[i].a, DIR_ROWS[i].b, DIR_ROWS[i].d,
                     DIR_ROWS[i].typed, '{DIR_ROWS[i].quot, DIR_ROWS[i].zdiv});

        // Random traffic in bursts with gaps
        n = 0;
        while (n < N_RANDOM)
        begin
            burst = $urandom_range(1, 40);
            for (k = 0; k < burst && n < N_RANDOM; k++)
            begin
                act = 1'($urandom_range(0, 1));
                a   = rand_operand();
                b   = rand_operand();
                d   = ($urandom_range(0, 15) == 0) ? '0 : rand_operand();
                send_txn(act, a, b, d, 1'b0, none);
                n++;
                // halfway: let the pipeline empty completely
                if (n == N_RANDOM / 2)
                begin
                    start <= 1'b0;
                    @(posedge clk);
                    while (pending_q.size() != 0)
                        @(posedge clk);
                end
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        start <= 1'b0;

        // Drain, then wait on for any stray results
        @(posedge clk);
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (3 * LATENCY) @(posedge clk);

        if (err_cnt == 0 && pending_q.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
